// ===== design/mau_pkg.sv =====
`default_nettype none
package mau_pkg;

  localparam int unsigned MODULUS_BITS_DEF = 31;
  localparam int unsigned WIDE_BITS = 64;
  localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_POW = 3'd4,
    FUNC_NEG = 3'd5,
    FUNC_INV = 3'd6,
    FUNC_RED = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_INV_SETUP,
    ST_EXP_STEP,
    ST_EXP_MUL_R,
    ST_EXP_MUL_B,
    ST_FINAL_MUL,
    ST_RED_W,
    ST_DONE
  } state_t;

  // Shared modular unit command/status
  typedef struct packed {
    logic start;
    logic wide;
  } mu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mu_sts_t;

endpackage
`default_nettype wire

// ===== design/modular_arithmetic_unit_core.sv =====
`default_nettype none
// Modular arithmetic unit over a prime modulus.
// Input channel (in_valid/in_ready) carries func, operand_a, operand_b and
// wide_operand; output channel (out_valid/out_ready) returns one residue beat
// per input beat, in order.
// The user must write the modulus register with modulus_we/modulus_wdata
// only while idle; the block itself does not enforce it. Only its low
// MODULUS_BITS bits are kept. Reset loads 1000000007.
// One shared bit-serial engine does every multiply and reduction.
// From accept to out_valid: add/sub/neg take two operand reductions plus
// dispatch; mul adds one modular multiply; reduce adds one 64-bit reduction;
// inverse and div up to about 2*MODULUS_BITS multiplies more; pow with a
// 64-bit exponent up to 125 multiplies plus an inverse when negative.
// One item is in flight at a time: in_ready is high only when idle.
// Reset returns the sequencer to idle and drops any item in progress.
// When the receiver stalls, the result holds on residue with out_valid high
// and no new beat is accepted until it is taken.
module modular_arithmetic_unit_core #(
  parameter int unsigned MODULUS_BITS = mau_pkg::MODULUS_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  func,
  input  wire  [30:0] operand_a,
  input  wire  [30:0] operand_b,
  input  wire  [63:0] wide_operand,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [30:0] residue,
  input  wire         modulus_we,
  input  wire  [30:0] modulus_wdata
);
  import mau_pkg::*;

  logic [MODULUS_BITS-1:0] modulus;
  logic [MODULUS_BITS-1:0] res;
  logic [MODULUS_BITS-1:0] mu_y;
  logic [MODULUS_BITS-1:0] mu_q;
  logic [63:0]             mu_x;
  mu_ctl_t                 mu_ctl;
  mu_sts_t                 mu_sts;

  // Hold the modulus; keep low bits only
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET[MODULUS_BITS-1:0];
    end else if (modulus_we) begin
      modulus <= modulus_wdata[MODULUS_BITS-1:0];
    end
  end

  mau_ctrl #(.MB(MODULUS_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .operand_a(operand_a), .operand_b(operand_b),
    .wide_operand(wide_operand), .m(modulus),
    .out_valid(out_valid), .out_ready(out_ready), .res(res),
    .mu_ctl(mu_ctl), .mu_x(mu_x), .mu_y(mu_y), .mu_sts(mu_sts), .mu_q(mu_q)
  );

  mau_modmul #(.MB(MODULUS_BITS)) u_modmul (
    .clk(clk), .rst(rst), .ctl(mu_ctl), .x(mu_x), .y(mu_y), .m(modulus),
    .sts(mu_sts), .q(mu_q)
  );

  assign residue = 31'(res);
endmodule
`default_nettype wire

// ===== design/mau_modmul.sv =====
`default_nettype none
// Shift-and-reduce engine: computes (x * y) mod m one bit of x per cycle,
// or reduces a 64-bit magnitude x mod m (y ignored) one bit per cycle.
module mau_modmul #(
  parameter int unsigned MB = mau_pkg::MODULUS_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  mau_pkg::mu_ctl_t   ctl,
  input  wire  [63:0]        x,
  input  wire  [MB-1:0]      y,
  input  wire  [MB-1:0]      m,
  output mau_pkg::mu_sts_t   sts,
  output logic [MB-1:0]      q
);
  import mau_pkg::*;

  logic [63:0]   xs;
  logic [6:0]    cnt;
  logic          busy;
  logic          done;
  logic          wide;
  logic [MB:0]   dbl;
  logic [MB+1:0] sum;
  logic [MB+1:0] red1;
  logic [MB-1:0] acc_next;

  // Doubling then add of y (or of the next bit), two conditional subtracts
  always_comb begin
    dbl = {q, xs[63]};
    if (!wide) begin
      dbl = {q, 1'b0};
    end
    if (dbl >= {1'b0, m}) begin
      dbl = dbl - {1'b0, m};
    end
    sum = {1'b0, dbl};
    if (!wide && xs[63]) begin
      sum = sum + {2'b0, y};
    end
    red1 = sum;
    if (red1 >= {2'b0, m}) begin
      red1 = red1 - {2'b0, m};
    end
    acc_next = red1[MB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      wide <= ctl.wide;
      q    <= '0;
      if (ctl.wide) begin
        xs  <= x;
        cnt <= 7'd63;
      end else begin
        xs  <= {x[MB-1:0], {(64-MB){1'b0}}};
        cnt <= 7'(MB - 1);
      end
    end else if (busy) begin
      q   <= acc_next;
      xs  <= {xs[62:0], 1'b0};
      cnt <= cnt - 7'd1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule
`default_nettype wire

// ===== design/mau_ctrl.sv =====
`default_nettype none
// Sequencer: drives the shared modular engine through reduce, exponent and
// multiply steps for each operation.
module mau_ctrl #(
  parameter int unsigned MB = mau_pkg::MODULUS_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         func,
  input  wire  [30:0]        operand_a,
  input  wire  [30:0]        operand_b,
  input  wire  [63:0]        wide_operand,
  input  wire  [MB-1:0]      m,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [MB-1:0]      res,
  output mau_pkg::mu_ctl_t   mu_ctl,
  output logic [63:0]        mu_x,
  output logic [MB-1:0]      mu_y,
  input  mau_pkg::mu_sts_t   mu_sts,
  input  wire  [MB-1:0]      mu_q
);
  import mau_pkg::*;

  state_t        state;
  state_t        state_next;
  func_t         op;
  logic [63:0]   w;
  logic [30:0]   opa;
  logic [30:0]   opb;
  logic [MB-1:0] a;
  logic [MB-1:0] b;
  logic [MB-1:0] r;
  logic [MB-1:0] base;
  logic [MB-1:0] mult;
  logic [63:0]   e;
  logic          inv_phase;
  logic          neg_w;
  logic          issued;
  logic          small_m;
  logic [MB:0]   add_s;
  logic [MB:0]   sub_s;
  logic [63:0]   mag_w;

  assign small_m = (m < MB'(2));
  assign mag_w   = (~w) + 64'd1;
  assign add_s   = {1'b0, a} + {1'b0, b};
  assign sub_s   = {1'b0, a} + {1'b0, m} - {1'b0, b};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (small_m) begin
          state_next = ST_DONE;
        end else if (issued && mu_sts.done) begin
          state_next = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (issued && mu_sts.done) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (op)
          FUNC_ADD, FUNC_SUB, FUNC_NEG: state_next = ST_DONE;
          FUNC_MUL: state_next = ST_FINAL_MUL;
          FUNC_RED: state_next = ST_RED_W;
          default: state_next = ST_INV_SETUP;
        endcase
      end
      ST_INV_SETUP: state_next = ST_EXP_STEP;
      ST_EXP_STEP: begin
        if (e == 64'd0) begin
          if (inv_phase && op == FUNC_POW) begin
            state_next = ST_INV_SETUP;
          end else if (op == FUNC_DIV) begin
            state_next = ST_FINAL_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end else if (e[0]) begin
          state_next = ST_EXP_MUL_R;
        end else begin
          state_next = ST_EXP_MUL_B;
        end
      end
      ST_EXP_MUL_R: begin
        if (issued && mu_sts.done) begin
          state_next = (e[63:1] == 63'd0) ? ST_EXP_STEP : ST_EXP_MUL_B;
        end
      end
      ST_EXP_MUL_B: begin
        if (issued && mu_sts.done) begin
          state_next = ST_EXP_STEP;
        end
      end
      ST_FINAL_MUL, ST_RED_W: begin
        if (issued && mu_sts.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Engine command for the current step
  always_comb begin
    mu_ctl.start = 1'b0;
    mu_ctl.wide  = 1'b0;
    mu_x         = '0;
    mu_y         = '0;
    case (state)
      ST_RED_A: begin
        mu_ctl.start = !issued && !small_m;
        mu_ctl.wide  = 1'b1;
        mu_x         = {33'd0, opa};
      end
      ST_RED_B: begin
        mu_ctl.start = !issued;
        mu_ctl.wide  = 1'b1;
        mu_x         = {33'd0, opb};
      end
      ST_EXP_MUL_R: begin
        mu_ctl.start = !issued;
        mu_x         = 64'(r);
        mu_y         = base;
      end
      ST_EXP_MUL_B: begin
        mu_ctl.start = !issued;
        mu_x         = 64'(base);
        mu_y         = base;
      end
      ST_FINAL_MUL: begin
        mu_ctl.start = !issued;
        mu_x         = 64'(a);
        mu_y         = mult;
      end
      ST_RED_W: begin
        mu_ctl.start = !issued;
        mu_ctl.wide  = 1'b1;
        mu_x         = neg_w ? mag_w : w;
      end
      default: begin
        mu_ctl.start = 1'b0;
      end
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign res       = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        issued <= 1'b0;
      end else if (mu_ctl.start) begin
        issued <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op    <= func_t'(func);
        opa   <= operand_a;
        opb   <= operand_b;
        w     <= wide_operand;
        neg_w <= wide_operand[63];
        r     <= '0;
        inv_phase <= 1'b0;
      end
      ST_RED_A: if (mu_sts.done) a <= mu_q;
      ST_RED_B: if (mu_sts.done) b <= mu_q;
      ST_DISPATCH: begin
        case (op)
          FUNC_ADD: r <= (add_s >= {1'b0, m}) ? add_s[MB-1:0] - m : add_s[MB-1:0];
          FUNC_SUB: r <= (a >= b) ? a - b : sub_s[MB-1:0];
          FUNC_NEG: r <= (a == '0) ? '0 : m - a;
          FUNC_MUL: mult <= b;
          FUNC_POW: inv_phase <= neg_w;
          default: inv_phase <= 1'b1;
        endcase
      end
      ST_INV_SETUP: begin
        if (inv_phase) begin
          // Fermat: x^(m-2); zero maps to zero
          base <= (op == FUNC_DIV) ? b : a;
          if (((op == FUNC_DIV) ? b : a) == '0) begin
            e <= 64'd0;
            r <= '0;
          end else begin
            e <= 64'(m) - 64'd2;
            r <= MB'(1);
          end
        end else begin
          r    <= MB'(1);
          base <= (op == FUNC_POW && neg_w) ? r : a;
          e    <= neg_w ? mag_w : w;
        end
      end
      ST_EXP_STEP: begin
        if (e == 64'd0) begin
          inv_phase <= 1'b0;
          mult      <= r;
        end
      end
      ST_EXP_MUL_R: begin
        if (mu_sts.done) begin
          r <= mu_q;
          if (e[63:1] == 63'd0) e <= 64'd0;
        end
      end
      ST_EXP_MUL_B: begin
        if (mu_sts.done) begin
          base <= mu_q;
          e    <= {1'b0, e[63:1]};
        end
      end
      ST_FINAL_MUL: if (mu_sts.done) r <= mu_q;
      ST_RED_W: begin
        if (mu_sts.done) begin
          r <= (neg_w && mu_q != '0) ? m - mu_q : mu_q;
        end
      end
      default: begin
        r <= r;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== design/mau_checker.sv =====
`default_nettype none
module mau_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [30:0] residue
);
  // Never ready to take a beat while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(residue))
    else $error("result changed under stall");
  // Taking an input ends ready until the result is delivered
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");
  // Result taken returns to idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("no return to idle");
endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .residue(residue)
);
`default_nettype wire
